// ----- src/igfs_pkg.sv -----
// Shared types and constants for the idle-gap frame slotter.
`default_nettype none
package igfs_pkg;

    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned CMDQ_DEPTH = 4;
    localparam int unsigned CQW = $clog2(CMDQ_DEPTH);

    localparam int unsigned MIN_IV = 5;
    localparam int unsigned MAX_IV = 100;
    localparam int unsigned AVG_SHIFT = 3;

    localparam logic [9:0]  RST_LEAD    = 10'd2;
    localparam logic [9:0]  RST_PROBE   = 10'd3;
    localparam logic [9:0]  RST_GUARD   = 10'd2;
    localparam logic [9:0]  RST_HOLD    = 10'd50;
    localparam logic [13:0] RST_RECENT  = 14'd200;
    localparam logic [9:0]  RST_GRACE   = 10'd10;
    localparam logic [6:0]  RST_INITPER = 7'd16;

    typedef enum logic [1:0] {
        A_FIRST = 2'd0,
        A_DONE  = 2'd1,
        A_OFFER = 2'd2,
        A_TICK  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        R_PASS    = 3'd0,
        R_GRACE   = 3'd1,
        R_HELD    = 3'd2,
        R_GAP     = 3'd3,
        R_TIMEOUT = 3'd4,
        R_FULL    = 3'd5
    } t_reason;

    typedef enum logic [2:0] {
        CFG_LEAD    = 3'd0,
        CFG_PROBE   = 3'd1,
        CFG_GUARD   = 3'd2,
        CFG_HOLD    = 3'd3,
        CFG_RECENT  = 3'd4,
        CFG_GRACE   = 3'd5,
        CFG_INITPER = 3'd6
    } t_cfg_index;

    typedef enum logic {
        CMD_SINGLE = 1'b0,
        CMD_DRAIN  = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] time_ms;
        logic        probe_trails;
        logic        bypass;
        logic [15:0] frame_id;
    } t_in_item;

    typedef struct packed {
        logic [15:0] frame_tag;
        logic [31:0] offered_at;
        logic [2:0]  reason;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] at;
    } t_held;

    typedef struct packed {
        t_cmd_kind       kind;
        logic [15:0]     tag;
        logic [31:0]     at;
        t_reason         reason;
        logic [QCW-1:0]  count;
    } t_cmd;

endpackage
`default_nettype wire

// ----- src/idle_gap_frame_slotter.sv -----
// Top level of the idle-gap frame slotter: front end, command queue, RAM, back end.
// Path: an input transfer is written into the command queue, and the back end pops it and
// registers its single result; a draining tick's frames also pass through the registered RAM read.
// Throughput: one event per cycle while the command queue is not full; a draining tick stalls
// input until all its held frames have been loaded out, and the stall grows when commands
// are queued ahead or the output is held off.
// Reset: synchronous, active low; hold RAM not cleared, only entries below the fill count are read.
`default_nettype none
module idle_gap_frame_slotter (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire igfs_pkg::t_in_item   i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output igfs_pkg::t_out_item       o_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [13:0]          i_cfg_data
);
    import igfs_pkg::*;

    logic           cmd_push, cmd_pop, cmd_empty, cmd_full;
    t_cmd           cmd_in, cmd_head;
    logic           wr_en, rd_en, drain_done;
    logic [QIW-1:0] wr_addr, rd_addr;
    t_held          wr_data, rd_data;

    assign o_cfg_ready = 1'b1;

    igfs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd_full   (cmd_full),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .i_drain_done (drain_done)
    );

    igfs_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_head  (cmd_head),
        .o_empty (cmd_empty),
        .o_full  (cmd_full)
    );

    igfs_ram #(
        .WIDTH ($bits(t_held)),
        .DEPTH (QUEUE_DEPTH),
        .AW    (QIW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    igfs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (cmd_head),
        .i_empty      (cmd_empty),
        .o_pop        (cmd_pop),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_drain_done (drain_done),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out)
    );

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> !cmd_full)
        else $error("command pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command popped from empty queue");

    a_not_last_is_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.last) |->
            (o_out.reason == R_GAP || o_out.reason == R_TIMEOUT))
        else $error("non-final transfer outside a drain");

    a_no_ram_write_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> !wr_en)
        else $error("hold RAM written during a drain");
`endif

endmodule
`default_nettype wire

// ----- src/igfs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module igfs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- src/igfs_front.sv -----
// Front end: event classification, period training, hold queue bookkeeping.
`default_nettype none
module igfs_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire igfs_pkg::t_in_item  i_in,
    input  wire logic                i_cfg_valid,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [13:0]         i_cfg_data,
    input  wire logic                i_cmd_full,
    output logic                     o_cmd_push,
    output igfs_pkg::t_cmd           o_cmd,
    output logic                     o_wr_en,
    output logic [igfs_pkg::QIW-1:0] o_wr_addr,
    output igfs_pkg::t_held          o_wr_data,
    input  wire logic                i_drain_done
);
    import igfs_pkg::*;

    logic [9:0]  r_lead, r_probe, r_guard, r_hold, r_grace;
    logic [13:0] r_recent;

    logic           r_have_first, n_have_first;
    logic [31:0]    r_lft, n_lft;
    logic [15:0]    r_period, n_period;
    logic           r_have_video, n_have_video;
    logic [31:0]    r_lvt, n_lvt;
    logic           r_armed, n_armed;
    logic [31:0]    r_rel, n_rel;
    logic [31:0]    r_hold_start, n_hold_start;
    logic [QCW-1:0] r_count, n_count;
    logic           r_busy, n_busy;

    logic                accept;
    logic [31:0]         now;
    logic [33:0]         lhs_ms;
    logic signed [43:0]  lhs, rhs;
    logic                idle;
    logic [31:0]         iv;
    logic                train;
    logic signed [17:0]  delta, quot;
    logic [32:0]         rel_sum;
    logic [31:0]         since;
    logic                video, grace_ok, full;
    logic [31:0]         held_for;
    logic                due, expired;

    assign o_in_ready = !i_cmd_full && !r_busy;
    assign accept     = i_in_valid && o_in_ready;
    assign now        = i_in.time_ms;

    // idle gap prediction, exact in fixed point
    assign lhs_ms = {2'b0, now} + {24'b0, r_lead} + {24'b0, r_probe};
    assign lhs    = signed'({2'b0, lhs_ms, 8'b0});
    assign rhs    = signed'({4'b0, r_lft, 8'b0}) + signed'({28'b0, r_period})
                  - signed'({26'b0, r_guard, 8'b0});
    assign idle   = !r_have_first || (lhs < rhs);

    // period training, eighth-step average rounded toward zero
    assign iv    = now - r_lft;
    assign train = r_have_first && (now > r_lft) && (iv >= 32'(MIN_IV))
                && (iv <= 32'(MAX_IV));
    assign delta = signed'({3'b0, iv[6:0], 8'b0}) - signed'({2'b0, r_period});
    assign quot  = (delta < 0) ? ((delta + 18'sd7) >>> AVG_SHIFT)
                               : (delta >>> AVG_SHIFT);

    assign rel_sum = {1'b0, now} + (i_in.probe_trails ? {23'b0, r_probe} : 33'd0);

    assign since    = now - r_lvt;
    assign video    = r_have_video && (now >= r_lvt) && (since <= {18'b0, r_recent});
    assign grace_ok = (since >= {22'b0, r_probe}) && (since <= {22'b0, r_grace}) && idle;
    assign full     = (r_count >= QCW'(QUEUE_DEPTH));

    assign held_for = now - r_hold_start;
    assign due      = r_armed && (now >= r_rel);
    assign expired  = (now >= r_hold_start) && (held_for >= {22'b0, r_hold});

    assign o_wr_addr      = r_count[QIW-1:0];
    assign o_wr_data.tag  = i_in.frame_id;
    assign o_wr_data.at   = now;

    always_comb begin
        n_have_first = r_have_first;
        n_lft        = r_lft;
        n_period     = r_period;
        n_have_video = r_have_video;
        n_lvt        = r_lvt;
        n_armed      = r_armed;
        n_rel        = r_rel;
        n_hold_start = r_hold_start;
        n_count      = r_count;
        n_busy       = r_busy && !i_drain_done;
        o_cmd_push   = 1'b0;
        o_wr_en      = 1'b0;
        o_cmd.kind   = CMD_SINGLE;
        o_cmd.tag    = i_in.frame_id;
        o_cmd.at     = now;
        o_cmd.reason = R_PASS;
        o_cmd.count  = r_count;
        if (accept) begin
            case (t_action'(i_in.action))
                A_FIRST: begin
                    if (train) begin
                        n_period = r_period + quot[15:0];
                    end
                    n_lft        = now;
                    n_have_first = 1'b1;
                end
                A_DONE: begin
                    n_lvt        = now;
                    n_have_video = 1'b1;
                    if ((r_count != '0) && idle) begin
                        n_armed = 1'b1;
                        n_rel   = rel_sum[32] ? 32'hFFFF_FFFF : rel_sum[31:0];
                    end
                end
                A_OFFER: begin
                    o_cmd_push = 1'b1;
                    if ((r_hold == '0) || i_in.bypass || !video) begin
                        o_cmd.reason = R_PASS;
                    end else if (grace_ok) begin
                        o_cmd.reason = R_GRACE;
                    end else if (full) begin
                        o_cmd.reason = R_FULL;
                    end else begin
                        o_cmd.reason = R_HELD;
                        o_wr_en      = 1'b1;
                        n_count      = r_count + 1'b1;
                        if (r_count == '0) begin
                            n_hold_start = now;
                        end
                    end
                end
                A_TICK: begin
                    if (r_count == '0) begin
                        n_armed = 1'b0;
                    end else if (due || expired) begin
                        o_cmd_push   = 1'b1;
                        o_cmd.kind   = CMD_DRAIN;
                        o_cmd.reason = due ? R_GAP : R_TIMEOUT;
                        n_count      = '0;
                        n_armed      = 1'b0;
                        n_busy       = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        // writing the initial period reloads the estimate
        if (i_cfg_valid && (t_cfg_index'(i_cfg_index) == CFG_INITPER)) begin
            n_period = {1'b0, i_cfg_data[6:0], 8'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead       <= RST_LEAD;
            r_probe      <= RST_PROBE;
            r_guard      <= RST_GUARD;
            r_hold       <= RST_HOLD;
            r_recent     <= RST_RECENT;
            r_grace      <= RST_GRACE;
            r_have_first <= 1'b0;
            r_lft        <= '0;
            r_period     <= {1'b0, RST_INITPER, 8'b0};
            r_have_video <= 1'b0;
            r_lvt        <= '0;
            r_armed      <= 1'b0;
            r_rel        <= '0;
            r_hold_start <= '0;
            r_count      <= '0;
            r_busy       <= 1'b0;
        end else begin
            r_have_first <= n_have_first;
            r_lft        <= n_lft;
            r_period     <= n_period;
            r_have_video <= n_have_video;
            r_lvt        <= n_lvt;
            r_armed      <= n_armed;
            r_rel        <= n_rel;
            r_hold_start <= n_hold_start;
            r_count      <= n_count;
            r_busy       <= n_busy;
            if (i_cfg_valid) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_LEAD:    r_lead   <= i_cfg_data[9:0];
                    CFG_PROBE:   r_probe  <= i_cfg_data[9:0];
                    CFG_GUARD:   r_guard  <= i_cfg_data[9:0];
                    CFG_HOLD:    r_hold   <= i_cfg_data[9:0];
                    CFG_RECENT:  r_recent <= i_cfg_data;
                    CFG_GRACE:   r_grace  <= i_cfg_data[9:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/igfs_cmdq.sv -----
// Short command queue between the front end and the result sequencer.
`default_nettype none
module igfs_cmdq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire igfs_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output igfs_pkg::t_cmd      o_head,
    output logic                o_empty,
    output logic                o_full
);
    import igfs_pkg::*;

    t_cmd             r_mem [CMDQ_DEPTH];
    logic [CQW-1:0]   r_wr, r_rd;
    logic [CQW:0]     r_cnt;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (CQW+1)'(CMDQ_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- src/igfs_back.sv -----
// Back end: turns commands into result transfers, draining held frames from RAM.
`default_nettype none
module igfs_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire igfs_pkg::t_cmd      i_head,
    input  wire logic                i_empty,
    output logic                     o_pop,
    output logic                     o_rd_en,
    output logic [igfs_pkg::QIW-1:0] o_rd_addr,
    input  wire igfs_pkg::t_held     i_rd_data,
    output logic                     o_drain_done,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output igfs_pkg::t_out_item      o_out
);
    import igfs_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } t_state;

    t_state         r_state, n_state;
    logic [QIW-1:0] r_idx, n_idx;
    logic [QCW-1:0] r_cnt, n_cnt;
    t_reason        r_reason, n_reason;
    logic           n_out_valid;
    t_out_item      n_out;
    logic           out_free, last;

    assign out_free = !o_out_valid || i_out_ready;
    assign last     = (QCW'(r_idx) + 1'b1) == r_cnt;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_reason     = r_reason;
        n_out_valid  = o_out_valid && !i_out_ready;
        n_out        = o_out;
        o_pop        = 1'b0;
        o_rd_en      = 1'b0;
        o_rd_addr    = '0;
        o_drain_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty && out_free) begin
                    o_pop = 1'b1;
                    if (i_head.kind == CMD_SINGLE) begin
                        n_out_valid      = 1'b1;
                        n_out.frame_tag  = i_head.tag;
                        n_out.offered_at = i_head.at;
                        n_out.reason     = i_head.reason;
                        n_out.last       = 1'b1;
                    end else begin
                        o_rd_en  = 1'b1;
                        n_idx    = '0;
                        n_cnt    = i_head.count;
                        n_reason = i_head.reason;
                        n_state  = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.frame_tag  = i_rd_data.tag;
                    n_out.offered_at = i_rd_data.at;
                    n_out.reason     = r_reason;
                    n_out.last       = last;
                    if (last) begin
                        o_drain_done = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = r_idx + 1'b1;
                        n_idx     = r_idx + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_reason    <= R_PASS;
        end else begin
            r_state     <= n_state;
            o_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_reason    <= n_reason;
        end
        o_out <= n_out;
    end

endmodule
`default_nettype wire
